FILE: rtl/core/crlu_pkg.sv
`default_nettype none
package crlu_pkg;

   localparam int unsigned NumFields = 8;
   localparam int unsigned FieldWidth = 4;
   localparam int unsigned WordWidth = NumFields * FieldWidth;

   // Request codes; code 7 is unused and falls to the default arm.
   typedef enum logic [2:0] {
      REQ_READ_CR      = 3'd0,
      REQ_WRITE_FIELDS = 3'd1,
      REQ_COPY_FIELD   = 3'd2,
      REQ_XER_TO_FIELD = 3'd3,
      REQ_BIT_LOGIC    = 3'd4,
      REQ_WRITE_XER    = 3'd5,
      REQ_READ_XER     = 3'd6
   } req_code_type;

   typedef enum logic [2:0] {
      LOP_NOR  = 3'd0,
      LOP_ANDC = 3'd1,
      LOP_XOR  = 3'd2,
      LOP_NAND = 3'd3,
      LOP_AND  = 3'd4,
      LOP_EQV  = 3'd5,
      LOP_ORC  = 3'd6,
      LOP_OR   = 3'd7
   } logic_op_type;

   // One registered request as handed to the execute logic.
   typedef struct packed {
      logic [2:0]           code;
      logic [WordWidth-1:0] write_value;
      logic [NumFields-1:0] field_mask;
      logic [2:0]           source_field;
      logic [2:0]           dest_field;
      logic [4:0]           bit_a;
      logic [4:0]           bit_b;
      logic [4:0]           bit_d;
      logic [2:0]           logic_op;
   } request_type;

   // Packed CR: element 7 is field 0, so CR bit i sits at packed bit 31 - i.
   typedef logic [NumFields-1:0][FieldWidth-1:0] cr_word_type;

endpackage
`default_nettype wire

FILE: rtl/core/condition_register_unit_core.sv
`default_nettype none
// Condition register unit: holds the eight 4-bit CR fields and the XER word and
// executes one request per transaction (read CR, masked field write, field copy,
// XER-to-field move, CR bit logic, XER write, XER read). Every request returns
// exactly one result word on the rsp_ channel: the packed CR or XER for reads,
// zero otherwise. A request is captured in an input register and executes once
// the result register is free, when it updates CR/XER and loads the result
// register that drives rsp_valid; the sustained rate, while rsp_ready stays high,
// is one transaction per cycle. State updates happen in request order, so
// back-to-back requests always see the effect of their predecessors. Both
// stages hold while the result register is full and rsp_ready is low; reset
// clears CR and XER to zero.
module condition_register_unit_core (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_valid,
   output logic            req_ready,
   input  var logic [2:0]  req_type,
   input  var logic [31:0] req_write_value,
   input  var logic [7:0]  req_field_mask,
   input  var logic [2:0]  req_source_field,
   input  var logic [2:0]  req_dest_field,
   input  var logic [4:0]  req_bit_a,
   input  var logic [4:0]  req_bit_b,
   input  var logic [4:0]  req_bit_d,
   input  var logic [2:0]  req_logic_op,
   output logic            rsp_valid,
   input  var logic        rsp_ready,
   output logic [31:0]     rsp_read_data
);

   // Input stage.
   logic                  req_valid_ff, req_valid_in;
   crlu_pkg::request_type req_ff, req_in;
   // Architectural state.
   crlu_pkg::cr_word_type cr_ff, cr_in;
   logic [31:0]           xer_ff, xer_in;
   // Result stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;

   crlu_pkg::cr_word_type exec_cr;
   logic [31:0]           exec_xer;
   logic [31:0]           exec_data;
   logic                  out_free;
   logic                  execute;
   logic                  req_take;

   // The result register can take a new word when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign execute   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   crlu_exec u_exec (
      .req       (req_ff),
      .cr        (cr_ff),
      .xer       (xer_ff),
      .cr_next   (exec_cr),
      .xer_next  (exec_xer),
      .read_data (exec_data)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      cr_in        = cr_ff;
      xer_in       = xer_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      // Drain the result register on a completed response transaction.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // Commit the registered request: update state, load the result.
      if (execute) begin
         cr_in        = exec_cr;
         xer_in       = exec_xer;
         rsp_valid_in = 1'b1;
         rsp_data_in  = exec_data;
         req_valid_in = 1'b0;
      end
      // Capture a new request transaction.
      if (req_take) begin
         req_valid_in        = 1'b1;
         req_in.code         = req_type;
         req_in.write_value  = req_write_value;
         req_in.field_mask   = req_field_mask;
         req_in.source_field = req_source_field;
         req_in.dest_field   = req_dest_field;
         req_in.bit_a        = req_bit_a;
         req_in.bit_b        = req_bit_b;
         req_in.bit_d        = req_bit_d;
         req_in.logic_op     = req_logic_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cr_ff        <= '0;
         xer_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cr_ff        <= cr_in;
         xer_ff       <= xer_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // A request that executes always yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      execute |=> rsp_valid)
      else $error("executed request produced no result");

   // Non-read requests return zero.
   assert property (@(posedge clock) disable iff (reset)
      execute && (req_ff.code != crlu_pkg::REQ_READ_CR)
              && (req_ff.code != crlu_pkg::REQ_READ_XER)
      |=> (rsp_read_data == 32'd0))
      else $error("non-read request returned nonzero data");

   // An XER move leaves the moved bits cleared.
   assert property (@(posedge clock) disable iff (reset)
      execute && (req_ff.code == crlu_pkg::REQ_XER_TO_FIELD)
      |=> (xer_ff[31:28] == 4'b0000))
      else $error("XER move did not clear XER[31:28]");

   // State changes only when a request executes.
   assert property (@(posedge clock) disable iff (reset)
      !execute |=> ($stable(cr_ff) && $stable(xer_ff)))
      else $error("CR or XER changed without an executing request");

endmodule
`default_nettype wire

FILE: rtl/core/crlu_exec.sv
`default_nettype none
module crlu_exec (
   input  var crlu_pkg::request_type req,
   input  var crlu_pkg::cr_word_type cr,
   input  var logic [31:0]           xer,
   output crlu_pkg::cr_word_type     cr_next,
   output logic [31:0]               xer_next,
   output logic [31:0]               read_data
);

   logic        bit_a_val;
   logic        bit_b_val;
   logic        bit_r;
   logic [31:0] cr_flat;
   logic [31:0] cr_bits_next;

   assign cr_flat = cr;
   // Field f lives at element ~f; CR bit i at packed bit ~i.
   assign bit_a_val = cr_flat[~req.bit_a];
   assign bit_b_val = cr_flat[~req.bit_b];

   always_comb begin
      case (req.logic_op)
         crlu_pkg::LOP_NOR:  bit_r = ~(bit_a_val | bit_b_val);
         crlu_pkg::LOP_ANDC: bit_r = bit_a_val & ~bit_b_val;
         crlu_pkg::LOP_XOR:  bit_r = bit_a_val ^ bit_b_val;
         crlu_pkg::LOP_NAND: bit_r = ~(bit_a_val & bit_b_val);
         crlu_pkg::LOP_AND:  bit_r = bit_a_val & bit_b_val;
         crlu_pkg::LOP_EQV:  bit_r = ~(bit_a_val ^ bit_b_val);
         crlu_pkg::LOP_ORC:  bit_r = bit_a_val | ~bit_b_val;
         crlu_pkg::LOP_OR:   bit_r = bit_a_val | bit_b_val;
         default:            bit_r = 1'b0;
      endcase
   end

   always_comb begin
      cr_next      = cr;
      xer_next     = xer;
      read_data    = '0;
      cr_bits_next = cr_flat;
      case (req.code)
         crlu_pkg::REQ_READ_CR: begin
            read_data = cr_flat;
         end
         crlu_pkg::REQ_WRITE_FIELDS: begin
            for (int k = 0; k < crlu_pkg::NumFields; k++) begin
               if (req.field_mask[k]) begin
                  cr_next[k] = req.write_value[k*crlu_pkg::FieldWidth +: crlu_pkg::FieldWidth];
               end
            end
         end
         crlu_pkg::REQ_COPY_FIELD: begin
            cr_next[~req.dest_field] = cr[~req.source_field];
         end
         crlu_pkg::REQ_XER_TO_FIELD: begin
            cr_next[~req.dest_field] = xer[31:28];
            xer_next = {4'b0000, xer[27:0]};
         end
         crlu_pkg::REQ_BIT_LOGIC: begin
            cr_bits_next[~req.bit_d] = bit_r;
            cr_next = cr_bits_next;
         end
         crlu_pkg::REQ_WRITE_XER: begin
            xer_next = req.write_value;
         end
         crlu_pkg::REQ_READ_XER: begin
            read_data = xer;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: verif/crlu_checker.sv
module crlu_checker (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_valid,
   input  var logic        req_ready,
   input  var logic [2:0]  req_type,
   input  var logic [31:0] req_write_value,
   input  var logic [7:0]  req_field_mask,
   input  var logic [2:0]  req_source_field,
   input  var logic [2:0]  req_dest_field,
   input  var logic [4:0]  req_bit_a,
   input  var logic [4:0]  req_bit_b,
   input  var logic [4:0]  req_bit_d,
   input  var logic [2:0]  req_logic_op,
   input  var logic        rsp_valid,
   input  var logic        rsp_ready,
   input  var logic [31:0] rsp_read_data,
   output int              error_count,
   output int              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [3:0]  cr_shadow [crlu_pkg::NumFields];
   logic [31:0] xer_shadow;
   logic [31:0] read_data_queue [$];

   function automatic logic [31:0] packed_cr();
      logic [31:0] word;
      word = '0;
      for (int i = 0; i < crlu_pkg::NumFields; i++) word = {word[27:0], cr_shadow[i]};
      return word;
   endfunction

   function automatic logic cr_bit(logic [4:0] idx);
      return cr_shadow[idx[4:2]][3 - idx[1:0]];
   endfunction

   // Apply one request to the shadow CR/XER and return the read word it yields.
   function automatic logic [31:0] execute_request(
      logic [2:0] code, logic [31:0] value, logic [7:0] mask, logic [2:0] src,
      logic [2:0] dst, logic [4:0] a_idx, logic [4:0] b_idx, logic [4:0] d_idx,
      logic [2:0] op);
      logic [31:0] word;
      logic        a, b, r;
      word = '0;
      case (code)
         crlu_pkg::REQ_READ_CR: word = packed_cr();
         crlu_pkg::REQ_WRITE_FIELDS: begin
            for (int i = 0; i < crlu_pkg::NumFields; i++)
               if (mask[7 - i]) cr_shadow[i] = value[28 - 4 * i +: 4];
         end
         crlu_pkg::REQ_COPY_FIELD: cr_shadow[dst] = cr_shadow[src];
         crlu_pkg::REQ_XER_TO_FIELD: begin
            cr_shadow[dst] = xer_shadow[31:28];
            xer_shadow[31:28] = '0;
         end
         crlu_pkg::REQ_BIT_LOGIC: begin
            a = cr_bit(a_idx);
            b = cr_bit(b_idx);
            case (op)
               crlu_pkg::LOP_NOR:  r = ~(a | b);
               crlu_pkg::LOP_ANDC: r = a & ~b;
               crlu_pkg::LOP_XOR:  r = a ^ b;
               crlu_pkg::LOP_NAND: r = ~(a & b);
               crlu_pkg::LOP_AND:  r = a & b;
               crlu_pkg::LOP_EQV:  r = ~(a ^ b);
               crlu_pkg::LOP_ORC:  r = a | ~b;
               default:            r = a | b;
            endcase
            cr_shadow[d_idx[4:2]][3 - d_idx[1:0]] = r;
         end
         crlu_pkg::REQ_WRITE_XER: xer_shadow = value;
         crlu_pkg::REQ_READ_XER: word = xer_shadow;
         default: ;
      endcase
      return word;
   endfunction

   assign pending_count = read_data_queue.size();

   initial error_count = 0;

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         for (int i = 0; i < crlu_pkg::NumFields; i++) cr_shadow[i] = '0;
         xer_shadow = '0;
         read_data_queue.delete();
      end else begin
         // responses leave before new requests enter; latency keeps them apart
         if (rsp_valid && rsp_ready) begin
            if (read_data_queue.size() == 0) begin
               $error("unexpected transaction: read_data actual %h", rsp_read_data);
               error_count++;
            end else begin
               want = read_data_queue.pop_front();
               if (rsp_read_data !== want) begin
                  $error("read_data mismatch: expected %h actual %h", want, rsp_read_data);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            read_data_queue.push_back(execute_request(req_type, req_write_value,
               req_field_mask, req_source_field, req_dest_field, req_bit_a,
               req_bit_b, req_bit_d, req_logic_op));
      end
   end

endmodule

FILE: verif/tb_condition_register_unit_core.sv
module tb_condition_register_unit_core;
   timeunit 1ns;
   timeprecision 1ps;

   // Request code 7 has no operation behind it; the unit must answer zero.
   localparam logic [2:0] REQ_UNUSED = 3'd7;
   localparam int ItemsPerPhase = 400;
   localparam int StallLimit = 5000;
   localparam int DrainCycles = 8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [31:0] req_write_value;
   logic [7:0]  req_field_mask;
   logic [2:0]  req_source_field;
   logic [2:0]  req_dest_field;
   logic [4:0]  req_bit_a;
   logic [4:0]  req_bit_b;
   logic [4:0]  req_bit_d;
   logic [2:0]  req_logic_op;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;

   int error_count;
   int pending_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   int quiet_cycles;

   condition_register_unit_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_write_value  (req_write_value),
      .req_field_mask   (req_field_mask),
      .req_source_field (req_source_field),
      .req_dest_field   (req_dest_field),
      .req_bit_a        (req_bit_a),
      .req_bit_b        (req_bit_b),
      .req_bit_d        (req_bit_d),
      .req_logic_op     (req_logic_op),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data)
   );

   crlu_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_write_value  (req_write_value),
      .req_field_mask   (req_field_mask),
      .req_source_field (req_source_field),
      .req_dest_field   (req_dest_field),
      .req_bit_a        (req_bit_a),
      .req_bit_b        (req_bit_b),
      .req_bit_d        (req_bit_d),
      .req_logic_op     (req_logic_op),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver side: redraw ready at every falling edge from the current stall rate.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves a transaction and
   // end the run once that count reaches the limit.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("tb_condition_register_unit_core: done, errors");
      $finish;
   end

   // Drive one request from a falling edge and hold it until accepted. Insert
   // sender idle cycles first, at the current idle rate. Leaves the process
   // at the falling edge after acceptance.
   task automatic send_req(logic [2:0] code, logic [31:0] value, logic [7:0] mask,
                           logic [2:0] src, logic [2:0] dst, logic [4:0] a_idx,
                           logic [4:0] b_idx, logic [4:0] d_idx, logic [2:0] op);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_type         = code;
      req_write_value  = value;
      req_field_mask   = mask;
      req_source_field = src;
      req_dest_field   = dst;
      req_bit_a        = a_idx;
      req_bit_b        = b_idx;
      req_bit_d        = d_idx;
      req_logic_op     = op;
      req_valid        = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_cr_op(logic [2:0] code, logic [31:0] value = '0,
                             logic [7:0] mask = '0, logic [2:0] src = '0,
                             logic [2:0] dst = '0);
      send_req(code, value, mask, src, dst, '0, '0, '0, crlu_pkg::LOP_NOR);
   endtask

   task automatic send_bit_op(logic [2:0] op, logic [4:0] a_idx, logic [4:0] b_idx,
                              logic [4:0] d_idx);
      send_req(crlu_pkg::REQ_BIT_LOGIC, $urandom, 8'($urandom), 3'($urandom),
               3'($urandom), a_idx, b_idx, d_idx, op);
   endtask

   // Random request mix: weight reads so that state changes are observed often,
   // and make empty and full masks common enough to show up in every phase.
   task automatic send_random_req();
      int          pick;
      logic [2:0]  code;
      logic [7:0]  mask;
      pick = $urandom_range(99);
      if (pick < 18)      code = crlu_pkg::REQ_READ_CR;
      else if (pick < 30) code = crlu_pkg::REQ_WRITE_FIELDS;
      else if (pick < 40) code = crlu_pkg::REQ_COPY_FIELD;
      else if (pick < 48) code = crlu_pkg::REQ_XER_TO_FIELD;
      else if (pick < 72) code = crlu_pkg::REQ_BIT_LOGIC;
      else if (pick < 82) code = crlu_pkg::REQ_WRITE_XER;
      else if (pick < 95) code = crlu_pkg::REQ_READ_XER;
      else                code = REQ_UNUSED;
      pick = $urandom_range(7);
      if (pick == 0)      mask = 8'h00;
      else if (pick == 1) mask = 8'hFF;
      else                mask = 8'($urandom);
      send_req(code, $urandom, mask, 3'($urandom), 3'($urandom), 5'($urandom),
               5'($urandom), 5'($urandom), 3'($urandom));
   endtask

   // Hold the sender until every outstanding transaction has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic run_phase(int idle_pct, int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (ItemsPerPhase) send_random_req();
      wait_drained();
   endtask

   initial begin
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_type           = crlu_pkg::REQ_READ_CR;
      req_write_value    = '0;
      req_field_mask     = '0;
      req_source_field   = '0;
      req_dest_field     = '0;
      req_bit_a          = '0;
      req_bit_b          = '0;
      req_bit_d          = '0;
      req_logic_op       = crlu_pkg::LOP_NOR;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset values, XER extremes and the XER move.
      send_cr_op(crlu_pkg::REQ_READ_CR);
      send_cr_op(crlu_pkg::REQ_READ_XER);
      send_cr_op(crlu_pkg::REQ_WRITE_XER, 32'hFFFF_FFFF);
      send_cr_op(crlu_pkg::REQ_READ_XER);
      send_cr_op(crlu_pkg::REQ_XER_TO_FIELD, '0, '0, '0, 3'd0);
      send_cr_op(crlu_pkg::REQ_READ_XER);
      send_cr_op(crlu_pkg::REQ_READ_CR);
      // Field writes: empty mask, full mask, single end fields.
      send_cr_op(crlu_pkg::REQ_WRITE_FIELDS, 32'hFFFF_FFFF, 8'h00);
      send_cr_op(crlu_pkg::REQ_WRITE_FIELDS, 32'hA5C3_F00F, 8'hFF);
      send_cr_op(crlu_pkg::REQ_WRITE_FIELDS, 32'h0000_0000, 8'h80);
      send_cr_op(crlu_pkg::REQ_WRITE_FIELDS, 32'hFFFF_FFFF, 8'h01);
      send_cr_op(crlu_pkg::REQ_READ_CR);
      // Copies: onto itself and between the end fields.
      send_cr_op(crlu_pkg::REQ_COPY_FIELD, '0, '0, 3'd3, 3'd3);
      send_cr_op(crlu_pkg::REQ_COPY_FIELD, '0, '0, 3'd7, 3'd0);
      send_cr_op(crlu_pkg::REQ_READ_CR);
      // Bit logic: every operation, end bits, destination aliasing a source.
      send_bit_op(crlu_pkg::LOP_NOR,  5'd0,  5'd31, 5'd0);
      send_bit_op(crlu_pkg::LOP_ANDC, 5'd31, 5'd0,  5'd31);
      send_bit_op(crlu_pkg::LOP_XOR,  5'd1,  5'd1,  5'd5);
      send_bit_op(crlu_pkg::LOP_NAND, 5'd4,  5'd30, 5'd30);
      send_bit_op(crlu_pkg::LOP_AND,  5'd7,  5'd8,  5'd16);
      send_bit_op(crlu_pkg::LOP_EQV,  5'd2,  5'd29, 5'd2);
      send_bit_op(crlu_pkg::LOP_ORC,  5'd12, 5'd31, 5'd3);
      send_bit_op(crlu_pkg::LOP_OR,   5'd31, 5'd31, 5'd0);
      send_cr_op(REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF, 3'd7, 3'd7);
      send_cr_op(crlu_pkg::REQ_READ_CR);
      wait_drained();

      // Random phases: no idling, sender idle, receiver stalling, both.
      run_phase(0, 0);
      run_phase(72, 0);
      run_phase(0, 72);
      run_phase(38, 38);

      // Let the pipeline settle, then give the verdict.
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_condition_register_unit_core: done, clean");
      end else begin
         $display("tb_condition_register_unit_core: done, errors");
      end
      $finish;
   end

endmodule
